### design/gmct_pkg.sv
// Shared types and constants for the gated multi-channel timeout block.
package gmct_pkg;

    // Number of timeout channels in the bank (1 to 32)
    localparam int CHANNELS = 5;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int INST_W  = 3;
    localparam int COUNT_W = 8;
    localparam int FLAGS_W = 5;

    // Width used to compare the requested channel number against each channel index
    localparam int CMP_W = 6;

    // Threshold after reset
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd10;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 2'd0,
        KIND_GATE      = 2'd1,
        KIND_CLR_COUNT = 2'd2,
        KIND_WR_EVENT  = 2'd3
    } kind_t;

    // Command handed from the top level to the channel bank
    typedef struct packed {
        logic              fire;
        kind_t             kind;
        logic [INST_W-1:0] inst;
        logic              value;
    } gmct_cmd_t;

endpackage

### design/gmct_if.sv
// Handshake interfaces for the command and result channels.
interface gmct_req_if
    import gmct_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [INST_W-1:0] instance_req;
    logic              value;

    modport source (output valid, output kind, output instance_req, output value,
                    input ready);
    modport sink   (input valid, input kind, input instance_req, input value,
                    output ready);
endinterface

interface gmct_rsp_if
    import gmct_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FLAGS_W-1:0] event_flags;
    logic               addressed_event;

    modport source (output valid, output event_flags, output addressed_event,
                    input ready);
    modport sink   (input valid, input event_flags, input addressed_event,
                    output ready);
endinterface

### design/gmct_bank.sv
// Channel bank: tick counters, gates, sticky event flags and the threshold.
module gmct_bank
    import gmct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  gmct_cmd_t          cmd,
    output logic [FLAGS_W-1:0] flags_next,
    output logic               addressed_next
);

    logic [COUNT_W-1:0]  threshold_reg;
    logic [COUNT_W-1:0]  count_reg  [CHANNELS];
    logic [COUNT_W-1:0]  count_next [CHANNELS];
    logic [CHANNELS-1:0] gate_reg;
    logic [CHANNELS-1:0] gate_next;
    logic [CHANNELS-1:0] event_reg;
    logic [CHANNELS-1:0] event_next;
    logic [CHANNELS-1:0] sel;

    // Per-channel update for the current item
    always_comb
    begin
        logic [COUNT_W-1:0] bumped;
        for (int i = 0; i < CHANNELS; i++)
        begin
            sel[i]        = (CMP_W'(i) == CMP_W'(cmd.inst));
            count_next[i] = count_reg[i];
            gate_next[i]  = gate_reg[i];
            event_next[i] = event_reg[i];
            bumped        = gate_reg[i] ? count_reg[i] + 1'b1 : count_reg[i];
            unique case (cmd.kind)
                KIND_TICK:
                begin
                    count_next[i] = bumped;
                    if (bumped > threshold_reg)
                        event_next[i] = 1'b1;
                end
                KIND_GATE:
                begin
                    if (sel[i])
                    begin
                        gate_next[i]  = cmd.value;
                        count_next[i] = '0;
                    end
                end
                KIND_CLR_COUNT:
                begin
                    if (sel[i])
                        count_next[i] = '0;
                end
                KIND_WR_EVENT:
                begin
                    if (sel[i])
                        event_next[i] = cmd.value;
                end
                default:
                begin
                    count_next[i] = count_reg[i];
                end
            endcase
        end
    end

    // Flag of the addressed channel; zero when out of range
    assign addressed_next = |(sel & event_next);

    // Only the low channels are visible in the flag field
    for (genvar j = 0; j < FLAGS_W; j++)
    begin : g_flags
        if (j < CHANNELS)
        begin : g_on
            assign flags_next[j] = event_next[j];
        end
        else
        begin : g_off
            assign flags_next[j] = 1'b0;
        end
    end

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_wr_en)
            threshold_reg <= cfg_wr_data;
    end

    // Channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg  <= '0;
            event_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
                count_reg[i] <= '0;
        end
        else if (cmd.fire)
        begin
            gate_reg  <= gate_next;
            event_reg <= event_next;
            for (int i = 0; i < CHANNELS; i++)
                count_reg[i] <= count_next[i];
        end
    end

endmodule

### design/gated_multi_channel_timeout.sv
// Top level of the gated multi-channel timeout block.
//
// Usage:
//   req carries one item per handshake: kind (tick, gate command, clear
//   counter, write event), instance_req and value. A tick advances every
//   gated counter and raises the sticky event of any counter above the
//   threshold; the other kinds act on one channel, and a channel number
//   past the bank is ignored.
//   rsp returns one item per request: all visible event flags and the
//   flag of the addressed channel, both as they stand after the request.
//   cfg_wr_en / cfg_wr_data write the timeout threshold; write it only
//   while no request is outstanding.
// Result and throughput:
//   The result is registered when the request is taken. The
//   bank update is a single pass of logic, so one item is taken every
//   cycle as long as the result register is empty or being drained.
// Reset:
//   Counters and flags clear, gates close, threshold returns to 10.
// Stall:
//   While rsp is held off with a result waiting, req.ready stays low.
module gated_multi_channel_timeout
    import gmct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    gmct_req_if.sink           req,
    gmct_rsp_if.source         rsp
);

    gmct_cmd_t          cmd;
    logic               accept;
    logic [FLAGS_W-1:0] flags_next;
    logic               addressed_next;
    logic               rsp_valid_reg;
    logic [FLAGS_W-1:0] flags_reg;
    logic               addressed_reg;

    // Take a new item when the result register is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign cmd.fire  = accept;
    assign cmd.kind  = kind_t'(req.kind);
    assign cmd.inst  = req.instance_req;
    assign cmd.value = req.value;

    gmct_bank u_bank (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .flags_next     (flags_next),
        .addressed_next (addressed_next)
    );

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg     <= flags_next;
            addressed_reg <= addressed_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.event_flags     = flags_reg;
    assign rsp.addressed_event = addressed_reg;

endmodule
